// File: src/arpc_pkg.sv
// Shared types and constants for the ARP cache and responder.
// Used by the cache cell, the top level and the property checker.
package arpc_pkg;

    localparam int CACHE_ENTRIES = 16;

    localparam int IP_W    = 32;
    localparam int MAC_W   = 48;
    localparam int FIELD_W = 16;
    localparam int STAT_W  = 3;

    localparam int IN_DATA_W  = 192;
    localparam int OUT_DATA_W = 136;

    localparam logic [FIELD_W-1:0] HW_ETHERNET  = 16'h0001;
    localparam logic [FIELD_W-1:0] PROTO_IPV4   = 16'h0800;
    localparam logic [FIELD_W-1:0] OPC_REQUEST  = 16'h0001;
    localparam logic [FIELD_W-1:0] OPC_REPLY    = 16'h0002;
    localparam logic [IP_W-1:0]    IP_BROADCAST = 32'hffff_ffff;

    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_BAD_HW    = 3'd1;
    localparam logic [STAT_W-1:0] ST_BAD_PROTO = 3'd2;
    localparam logic [STAT_W-1:0] ST_OWN       = 3'd3;
    localparam logic [STAT_W-1:0] ST_BAD_OP    = 3'd4;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd5;

    localparam logic REQ_PACKET = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    localparam logic CFG_OWN_IP  = 1'b0;
    localparam logic CFG_OWN_MAC = 1'b1;

    // What a token asks of the cells it passes.
    localparam logic [1:0] TOK_NONE   = 2'd0;
    localparam logic [1:0] TOK_LEARN  = 2'd1;
    localparam logic [1:0] TOK_LOOKUP = 2'd2;

    // Token handed from cell to cell. For a learn, mac carries the new MAC;
    // for a lookup it picks up the MAC of the first hit.
    typedef struct packed {
        logic             active;
        logic [1:0]       op;
        logic             found;
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
    } token_t;

    typedef struct packed {
        logic [MAC_W-1:0]  lookup_mac;
        logic              lookup_hit;
        logic              for_us;
        logic [IP_W-1:0]   reply_target_ip;
        logic [MAC_W-1:0]  reply_target_mac;
        logic              send_reply;
        logic [STAT_W-1:0] status;
    } result_t;

endpackage

// File: src/arpc_cell.sv
// One cache entry of the ARP cache, with the token register that follows it.
// Depends on arpc_pkg for the token type and its codes.
module arpc_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  arpc_pkg::token_t  tok_in,
    output arpc_pkg::token_t  tok_out
);

    logic                        valid_reg, valid_next;
    logic [arpc_pkg::IP_W-1:0]   ip_reg, ip_next;
    logic [arpc_pkg::MAC_W-1:0]  mac_reg, mac_next;
    arpc_pkg::token_t            tok_reg, tok_next;
    logic                        match;

    assign match = valid_reg && (ip_reg == tok_in.ip);

    // Entries fill strictly in order and are never freed, so the valid
    // entries form a prefix: when a learn meets the first free entry it has
    // already passed every entry that could have matched.
    always_comb
    begin
        valid_next = valid_reg;
        ip_next    = ip_reg;
        mac_next   = mac_reg;
        tok_next   = tok_in;
        if (tok_in.active && !tok_in.found)
        begin
            if (tok_in.op == arpc_pkg::TOK_LEARN)
            begin
                if (match)
                begin
                    mac_next       = tok_in.mac;
                    tok_next.found = 1'b1;
                end
                else if (!valid_reg)
                begin
                    valid_next     = 1'b1;
                    ip_next        = tok_in.ip;
                    mac_next       = tok_in.mac;
                    tok_next.found = 1'b1;
                end
            end
            else if (tok_in.op == arpc_pkg::TOK_LOOKUP)
            begin
                if (match)
                begin
                    tok_next.found = 1'b1;
                    tok_next.mac   = mac_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ip_reg  <= ip_next;
        mac_reg <= mac_next;
    end

    assign tok_out = tok_reg;

endmodule

// File: src/arp_cache_and_responder.sv
// Top level of the ARP cache and responder: input decode, the row of cache
// cells, result build and output register. Depends on arpc_pkg and arpc_cell.
//
// One item is in flight at a time. An accepted beat sends a token down the
// row of CACHE_ENTRIES cells, one cell per clock. The result is registered in
// a pending register and then in the output register, and the next input
// beat can be taken once the result has moved on to the output register.
// A result
// waiting on the output does not block the next input beat; only a second
// finished result that cannot move to the output holds the input closed. The
// cache is empty right after reset, with no clearing pass. The own MAC
// register is accepted on the configuration port but not stored here, since
// no result carries it.
module arp_cache_and_responder (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [arpc_pkg::MAC_W-1:0]     cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // hw_type, proto_type, arp_opcode, sender_ip, sender_mac, target_ip,
    // lookup_ip (from bit 0 up)
    input  logic [arpc_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // req_type
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // status, send_reply, reply_target_mac, reply_target_ip, for_us,
    // lookup_hit, lookup_mac (from bit 0 up), two zero pad bits on top
    output logic [arpc_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int N = arpc_pkg::CACHE_ENTRIES;

    logic [arpc_pkg::FIELD_W-1:0] in_hw, in_proto, in_opcode;
    logic [arpc_pkg::IP_W-1:0]    in_sender_ip, in_target_ip, in_lookup_ip;
    logic [arpc_pkg::MAC_W-1:0]   in_sender_mac;

    assign in_hw         = s_axis_tdata[15:0];
    assign in_proto      = s_axis_tdata[31:16];
    assign in_opcode     = s_axis_tdata[47:32];
    assign in_sender_ip  = s_axis_tdata[79:48];
    assign in_sender_mac = s_axis_tdata[127:80];
    assign in_target_ip  = s_axis_tdata[159:128];
    assign in_lookup_ip  = s_axis_tdata[191:160];

    logic [arpc_pkg::IP_W-1:0] own_ip_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            own_ip_reg <= '0;
        else if (cfg_we && cfg_index == arpc_pkg::CFG_OWN_IP)
            own_ip_reg <= cfg_data[arpc_pkg::IP_W-1:0];
    end

    // Item control
    logic accept;
    logic busy_reg;
    logic pend_valid_reg;
    logic out_valid_reg;
    logic pend_move;

    assign s_axis_tready = !busy_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign pend_move     = pend_valid_reg && (!out_valid_reg || m_axis_tready);

    // Header checks are done on the input beat and kept for the result.
    logic [arpc_pkg::STAT_W-1:0]  hdr_status;
    logic                         req_type_reg;
    logic [arpc_pkg::STAT_W-1:0]  hdr_status_reg;
    logic                         for_us_reg;
    logic                         own_reg;
    logic [arpc_pkg::FIELD_W-1:0] opcode_reg;
    logic [arpc_pkg::IP_W-1:0]    sender_ip_reg;
    logic [arpc_pkg::MAC_W-1:0]   sender_mac_reg;

    always_comb
    begin
        if (in_hw != arpc_pkg::HW_ETHERNET)
            hdr_status = arpc_pkg::ST_BAD_HW;
        else if (in_proto != arpc_pkg::PROTO_IPV4)
            hdr_status = arpc_pkg::ST_BAD_PROTO;
        else
            hdr_status = arpc_pkg::ST_OK;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_type_reg   <= s_axis_tuser;
            hdr_status_reg <= hdr_status;
            for_us_reg     <= (in_target_ip == own_ip_reg) ||
                              (in_target_ip == arpc_pkg::IP_BROADCAST);
            own_reg        <= (in_sender_ip == own_ip_reg);
            opcode_reg     <= in_opcode;
            sender_ip_reg  <= in_sender_ip;
            sender_mac_reg <= in_sender_mac;
        end
    end

    // Cell row
    arpc_pkg::token_t tok [N+1];

    always_comb
    begin
        tok[0].active = accept;
        tok[0].found  = 1'b0;
        if (s_axis_tuser == arpc_pkg::REQ_LOOKUP)
        begin
            tok[0].op  = arpc_pkg::TOK_LOOKUP;
            tok[0].ip  = in_lookup_ip;
            tok[0].mac = '0;
        end
        else
        begin
            tok[0].op  = (hdr_status == arpc_pkg::ST_OK) ? arpc_pkg::TOK_LEARN
                                                         : arpc_pkg::TOK_NONE;
            tok[0].ip  = in_sender_ip;
            tok[0].mac = in_sender_mac;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < N; gi++)
        begin : g_cell
            arpc_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .tok_in  (tok[gi]),
                .tok_out (tok[gi+1])
            );
        end
    endgenerate

    // Result build when the token leaves the last cell.
    arpc_pkg::result_t res;
    arpc_pkg::result_t pend_reg;
    arpc_pkg::result_t out_reg;

    always_comb
    begin
        res = '0;
        if (req_type_reg == arpc_pkg::REQ_LOOKUP)
        begin
            res.lookup_hit = tok[N].found;
            res.lookup_mac = tok[N].found ? tok[N].mac : '0;
        end
        else if (hdr_status_reg != arpc_pkg::ST_OK)
        begin
            res.status = hdr_status_reg;
        end
        else
        begin
            res.for_us = for_us_reg;
            if (!tok[N].found)
                res.status = arpc_pkg::ST_FULL;
            else if (own_reg)
                res.status = arpc_pkg::ST_OWN;
            else if (opcode_reg == arpc_pkg::OPC_REQUEST)
            begin
                res.send_reply       = 1'b1;
                res.reply_target_mac = sender_mac_reg;
                res.reply_target_ip  = sender_ip_reg;
            end
            else if (opcode_reg != arpc_pkg::OPC_REPLY)
                res.status = arpc_pkg::ST_BAD_OP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
                busy_reg <= 1'b1;
            else if (pend_move)
                busy_reg <= 1'b0;

            if (tok[N].active)
                pend_valid_reg <= 1'b1;
            else if (pend_move)
                pend_valid_reg <= 1'b0;

            if (pend_move)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok[N].active)
            pend_reg <= res;
        if (pend_move)
            out_reg <= pend_reg;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_reg};

endmodule

// File: src/arpc_props.sv
// Port-level properties of the ARP cache and responder, bound to the top.
// Depends on arpc_pkg for field widths and status codes.
module arpc_props (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [arpc_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    logic [arpc_pkg::STAT_W-1:0] o_status;
    logic                        o_send_reply;
    logic [arpc_pkg::MAC_W-1:0]  o_rmac;
    logic [arpc_pkg::IP_W-1:0]   o_rip;
    logic                        o_hit;
    logic [arpc_pkg::MAC_W-1:0]  o_lmac;

    assign o_status     = m_axis_tdata[2:0];
    assign o_send_reply = m_axis_tdata[3];
    assign o_rmac       = m_axis_tdata[51:4];
    assign o_rip        = m_axis_tdata[83:52];
    assign o_hit        = m_axis_tdata[85];
    assign o_lmac       = m_axis_tdata[133:86];

    // A stalled result beat keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // Only one item is in flight: the input closes right after a beat.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while an item is in flight");

    // A reply request comes only with OK status, never with a lookup hit.
    a_reply_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && o_send_reply |-> o_status == arpc_pkg::ST_OK && !o_hit)
        else $error("reply requested with error status or lookup hit");

    // Reply addresses are zero unless a reply is requested.
    a_reply_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !o_send_reply |-> o_rmac == '0 && o_rip == '0)
        else $error("reply addresses set without a reply");

    // A miss never carries a MAC.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !o_hit |-> o_lmac == '0)
        else $error("lookup MAC set on a miss");

endmodule

bind arp_cache_and_responder arpc_props u_arpc_props (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
